/* design/ibac_pkg.sv */
`timescale 1ns / 1ps

package ibac_pkg;

    localparam int BLK_W                 = 16;
    localparam int DISK_BLOCKS_DEF       = 1024;
    localparam int MAX_FILE_BLOCKS_DEF   = 64;

    typedef enum logic [1:0] {
        RSN_NONE     = 2'd0,
        RSN_IN_USE   = 2'd1,
        RSN_RANGE    = 2'd2,
        RSN_TOO_LONG = 2'd3
    } t_reason;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic    push;
        logic    allocated;
        t_reason reason;
    } t_res_push;

endpackage

/* design/ibac_ram.sv */
`timescale 1ns / 1ps

module ibac_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 10,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ibac_ctrl.sv */
`timescale 1ns / 1ps

module ibac_ctrl #(
    parameter int DISK_BLOCKS     = ibac_pkg::DISK_BLOCKS_DEF,
    parameter int MAX_FILE_BLOCKS = ibac_pkg::MAX_FILE_BLOCKS_DEF,
    localparam int AW = $clog2(DISK_BLOCKS),
    localparam int PW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1,
    localparam int CW = $clog2(MAX_FILE_BLOCKS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input beat
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ibac_pkg::BLK_W-1:0] i_blk,
    input  logic                      i_last,
    // output register
    input  logic                      i_out_busy,
    output ibac_pkg::t_res_push       o_res,
    // usage map
    output logic                      o_map_we,
    output logic [AW-1:0]             o_map_waddr,
    output logic                      o_map_wdata,
    output logic [AW-1:0]             o_map_raddr,
    input  logic                      i_map_rdata,
    // pending list
    output logic                      o_pend_we,
    output logic [PW-1:0]             o_pend_waddr,
    output logic [AW-1:0]             o_pend_wdata,
    output logic [PW-1:0]             o_pend_raddr,
    input  logic [AW-1:0]             i_pend_rdata
);

    import ibac_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_COMMIT,
        ST_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_blk;
    logic          r_last;
    logic          r_chk;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_wv;
    t_reason       r_fail;
    t_reason       n_fail;
    t_res_push     r_res;

    logic          full;
    logic          out_of_range;

    assign full         = (r_count >= CW'(MAX_FILE_BLOCKS));
    assign out_of_range = ({1'b0, i_blk} >= (BLK_W + 1)'(DISK_BLOCKS));

    always_comb begin
        n_fail = r_fail;
        if (r_chk && i_map_rdata) begin
            n_fail = RSN_IN_USE;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_res        = r_res;

    // single map write port: zero sweep after reset, then commit marks
    assign o_map_we     = (r_state == ST_CLEAR) || r_wv;
    assign o_map_waddr  = (r_state == ST_CLEAR) ? r_clr : i_pend_rdata;
    assign o_map_wdata  = (r_state != ST_CLEAR);
    assign o_map_raddr  = i_blk[AW-1:0];

    assign o_pend_we    = (r_state == ST_CHECK) && r_chk && !i_map_rdata;
    assign o_pend_waddr = r_count[PW-1:0];
    assign o_pend_wdata = r_blk;
    assign o_pend_raddr = r_idx[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_fail  <= RSN_NONE;
            r_chk   <= 1'b0;
            r_wv    <= 1'b0;
            r_res   <= '0;
        end else begin
            r_res.push <= (r_state == ST_DONE) && !i_out_busy;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DISK_BLOCKS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_blk   <= i_blk[AW-1:0];
                        r_last  <= i_last;
                        r_chk   <= 1'b0;
                        r_state <= ST_CHECK;
                        priority if (r_fail != RSN_NONE) begin
                            // list already failed: blocks are skipped
                        end else if (full) begin
                            r_fail <= RSN_TOO_LONG;
                        end else if (out_of_range) begin
                            r_fail <= RSN_RANGE;
                        end else begin
                            r_chk <= 1'b1;  // map word arrives next cycle
                        end
                    end
                end
                ST_CHECK: begin
                    r_fail <= n_fail;
                    r_chk  <= 1'b0;
                    if (o_pend_we) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (n_fail == RSN_NONE) begin
                        r_idx   <= '0;
                        r_state <= ST_COMMIT;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_COMMIT: begin
                    // read one entry a cycle, write it to the map the cycle after
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + 1'b1;
                        r_wv  <= 1'b1;
                    end else begin
                        r_wv    <= 1'b0;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!i_out_busy) begin
                        r_res.allocated <= (r_fail == RSN_NONE);
                        r_res.reason    <= r_fail;
                        r_count         <= '0;
                        r_fail          <= RSN_NONE;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/indexed_block_allocation_check_unit.sv */
`timescale 1ns / 1ps

// Allocation checker for indexed files against a disk usage bitmap. A file's
// block list arrives one block number per input beat, the final beat marked
// by tlast. Each block is refused when the list is already full (too long),
// when it lies at or beyond DISK_BLOCKS (range is tested before the map is
// read), or when the map shows it in use; only the first failure of a list is
// reported and later blocks are ignored. Accepted blocks are held in a
// pending buffer. The final beat yields one result beat: allocated = 1 and
// reason 0, or allocated = 0 and the reason code. Only a fully accepted list
// is marked used, entry by entry, so a rejected list never touches the map.
// Duplicates inside one list are not detected. A beat is taken in the idle
// state, which reads the map RAM, then checked and buffered in the check
// state with tready low. A final beat of an accepted list adds a commit walk
// through the pending RAM and a hand-over of the result before tready
// returns; a rejected one goes straight to the hand-over. After reset the map
// is swept to free, one block per cycle, and tready stays low until the sweep
// ends. The result sits in an output register; input beats keep flowing while
// it waits, and only a further final beat waits for it to drain.

module indexed_block_allocation_check_unit #(
    parameter int DISK_BLOCKS     = ibac_pkg::DISK_BLOCKS_DEF,
    parameter int MAX_FILE_BLOCKS = ibac_pkg::MAX_FILE_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] block_number
    input  logic        s_axis_tlast,   // last_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] allocated, [2:1] reject_reason, [7:3] zero
);

    import ibac_pkg::*;

    localparam int AW = $clog2(DISK_BLOCKS);
    localparam int PW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;

    t_res_push     res;
    logic          out_busy;

    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic          map_wdata;
    logic [AW-1:0] map_raddr;
    logic          map_rdata;

    logic          pend_we;
    logic [PW-1:0] pend_waddr;
    logic [AW-1:0] pend_wdata;
    logic [PW-1:0] pend_raddr;
    logic [AW-1:0] pend_rdata;

    // output register
    logic          r_out_valid;
    logic          r_out_alloc;
    t_reason       r_out_reason;

    assign out_busy = r_out_valid && !m_axis_tready;

    ibac_ctrl #(
        .DISK_BLOCKS     (DISK_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_blk        (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_out_busy   (out_busy),
        .o_res        (res),
        .o_map_we     (map_we),
        .o_map_waddr  (map_waddr),
        .o_map_wdata  (map_wdata),
        .o_map_raddr  (map_raddr),
        .i_map_rdata  (map_rdata),
        .o_pend_we    (pend_we),
        .o_pend_waddr (pend_waddr),
        .o_pend_wdata (pend_wdata),
        .o_pend_raddr (pend_raddr),
        .i_pend_rdata (pend_rdata)
    );

    // one bit per disk block, 1 = used
    ibac_ram #(
        .DEPTH (DISK_BLOCKS),
        .WIDTH (1)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // blocks of the list being built
    ibac_ram #(
        .DEPTH (MAX_FILE_BLOCKS),
        .WIDTH (AW)
    ) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.push) begin
            r_out_alloc  <= res.allocated;
            r_out_reason <= res.reason;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_reason, r_out_alloc};

endmodule

/* design/ibac_checker.sv */
`timescale 1ns / 1ps

module ibac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // allocated and a zero reason go together
    a_out_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == 2'd0)))
        else $error("allocated flag disagrees with reason");

    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0))
        else $error("result padding not zero");

    // a taken block beat is followed by its map check, with tready low
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken during block check");

endmodule

bind indexed_block_allocation_check_unit ibac_checker u_ibac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
